/* design/sdh_pkg.sv */
// Shared constants, result codes and controller/datapath link types.
`timescale 1ns / 1ps
package sdh_pkg;
    localparam int BUCKETS     = 4096;
    localparam int ENTRIES     = 4096;
    localparam int MAX_LEN     = 40;
    localparam int BKT_W       = $clog2(BUCKETS);
    localparam int ENT_W       = $clog2(ENTRIES);
    localparam int LINK_W      = $clog2(ENTRIES + 1);
    localparam int CLR_W       = $clog2(BUCKETS + 1);
    localparam int LEN_W       = $clog2(MAX_LEN + 1);
    localparam int CHAR_ADDR_W = $clog2(ENTRIES * MAX_LEN);
    localparam int HASH_W      = 32;
    localparam int CHAR_W      = 8;
    localparam int STAT_W      = 2;
    localparam int IDX_W       = 12;

    localparam logic [STAT_W-1:0] ST_NEW   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FIRST = 2'd1;
    localparam logic [STAT_W-1:0] ST_LATER = 2'd2;
    localparam logic [STAT_W-1:0] ST_DROP  = 2'd3;

    typedef struct packed {
        logic              clr_step;
        logic              accept;
        logic              hash_rd;
        logic              head_load;
        logic              ent_rd;
        logic              cmp_step;
        logic              advance;
        logic              mark_reported;
        logic              new_start;
        logic              copy_step;
        logic              link_write;
        logic              res_set;
        logic [STAT_W-1:0] res_code;
        logic              load_result;
        logic              clear_line;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic overlong;
        logic link_zero;
        logic len_match;
        logic len_zero;
        logic char_match;
        logic idx_at_len;
        logic pool_full;
        logic reported;
    } stat_t;
endpackage

/* design/sdh_if.sv */
// Valid/ready channel interfaces for characters and results.
`timescale 1ns / 1ps
interface sdh_char_if;
    logic                        valid;
    logic                        ready;
    logic [sdh_pkg::CHAR_W-1:0]  char_code;
    logic                        last_char;
    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface sdh_result_if;
    logic                        valid;
    logic                        ready;
    logic [sdh_pkg::STAT_W-1:0]  status;
    logic [sdh_pkg::IDX_W-1:0]   entry_index;
    modport source (output valid, output status, output entry_index, input ready);
    modport sink   (input valid, input status, input entry_index, output ready);
endinterface

/* design/sdh_datapath.sv */
// Hash, line buffer, bucket heads, entry pool and result registers.
`timescale 1ns / 1ps
module sdh_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sdh_pkg::cmd_t                     cmd,
    input  logic [sdh_pkg::CHAR_W-1:0]        char_code,
    output sdh_pkg::stat_t                    st,
    output logic [sdh_pkg::STAT_W-1:0]        result_status,
    output logic [sdh_pkg::IDX_W-1:0]         result_index
);
    logic [sdh_pkg::HASH_W-1:0]      hash_reg, hash_next;
    logic [sdh_pkg::LEN_W-1:0]       len_reg, len_next;
    logic                            overlong_reg, overlong_next;
    logic [sdh_pkg::LINK_W-1:0]      used_reg, used_next;
    logic [sdh_pkg::CLR_W-1:0]       clr_reg, clr_next;

    logic [sdh_pkg::LINK_W-1:0]      link_reg, tail_reg;
    logic [sdh_pkg::LEN_W-1:0]       idx_reg;
    logic [sdh_pkg::CHAR_ADDR_W-1:0] base_reg;
    logic [sdh_pkg::STAT_W-1:0]      res_status_reg, out_status_reg;
    logic [sdh_pkg::IDX_W-1:0]       res_index_reg, out_index_reg;

    logic [sdh_pkg::LINK_W-1:0] head_mem [sdh_pkg::BUCKETS];
    logic [sdh_pkg::CHAR_W-1:0] lbuf_mem [sdh_pkg::MAX_LEN];
    logic [sdh_pkg::CHAR_W-1:0] char_mem [sdh_pkg::ENTRIES * sdh_pkg::MAX_LEN];
    logic [sdh_pkg::LEN_W-1:0]  elen_mem [sdh_pkg::ENTRIES];
    logic [sdh_pkg::LINK_W-1:0] enext_mem [sdh_pkg::ENTRIES];
    logic                       erep_mem [sdh_pkg::ENTRIES];

    logic [sdh_pkg::LINK_W-1:0] head_rd, enext_rd;
    logic [sdh_pkg::CHAR_W-1:0] lbuf_rd, char_rd;
    logic [sdh_pkg::LEN_W-1:0]  elen_rd;
    logic                       erep_rd;

    logic [sdh_pkg::LINK_W-1:0] link_m1, tail_m1;
    logic [sdh_pkg::ENT_W-1:0]  cur_ent, tail_ent, used_ent;
    logic [sdh_pkg::LEN_W-1:0]  idx_m1;
    logic                       char_nz;

    logic                       head_we;
    logic [sdh_pkg::BKT_W-1:0]  head_wa;
    logic [sdh_pkg::LINK_W-1:0] head_wd;
    logic                       enext_we;
    logic [sdh_pkg::ENT_W-1:0]  enext_wa;
    logic [sdh_pkg::LINK_W-1:0] enext_wd;

    assign link_m1  = link_reg - sdh_pkg::LINK_W'(1);
    assign tail_m1  = tail_reg - sdh_pkg::LINK_W'(1);
    assign cur_ent  = link_m1[sdh_pkg::ENT_W-1:0];
    assign tail_ent = tail_m1[sdh_pkg::ENT_W-1:0];
    assign used_ent = used_reg[sdh_pkg::ENT_W-1:0];
    assign idx_m1   = idx_reg - sdh_pkg::LEN_W'(1);
    assign char_nz  = (char_code != '0);

    // Line accumulation and pool counters
    always_comb
    begin
        hash_next     = hash_reg;
        len_next      = len_reg;
        overlong_next = overlong_reg;
        used_next     = used_reg;
        clr_next      = clr_reg;
        if (cmd.clr_step)
        begin
            clr_next = clr_reg + sdh_pkg::CLR_W'(1);
        end
        if (cmd.accept && char_nz)
        begin
            hash_next = {hash_reg[sdh_pkg::HASH_W-6:0], hash_reg[sdh_pkg::HASH_W-1:sdh_pkg::HASH_W-5]}
                        + {{(sdh_pkg::HASH_W-sdh_pkg::CHAR_W){char_code[sdh_pkg::CHAR_W-1]}},
                           char_code};
            if (len_reg < sdh_pkg::LEN_W'(sdh_pkg::MAX_LEN))
            begin
                len_next = len_reg + sdh_pkg::LEN_W'(1);
            end
            else
            begin
                overlong_next = 1'b1;
            end
        end
        if (cmd.link_write)
        begin
            used_next = used_reg + sdh_pkg::LINK_W'(1);
        end
        if (cmd.clear_line)
        begin
            hash_next     = '0;
            len_next      = '0;
            overlong_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg     <= '0;
            len_reg      <= '0;
            overlong_reg <= 1'b0;
            used_reg     <= '0;
            clr_reg      <= '0;
        end
        else
        begin
            hash_reg     <= hash_next;
            len_reg      <= len_next;
            overlong_reg <= overlong_next;
            used_reg     <= used_next;
            clr_reg      <= clr_next;
        end
    end

    // Chain walk and copy registers
    always_ff @(posedge clk)
    begin
        if (cmd.head_load)
        begin
            link_reg <= head_rd;
            tail_reg <= '0;
        end
        else if (cmd.advance)
        begin
            tail_reg <= link_reg;
            link_reg <= enext_rd;
        end
        if (cmd.ent_rd)
        begin
            base_reg <= sdh_pkg::CHAR_ADDR_W'(cur_ent) * sdh_pkg::CHAR_ADDR_W'(sdh_pkg::MAX_LEN);
            idx_reg  <= '0;
        end
        else if (cmd.new_start)
        begin
            base_reg <= sdh_pkg::CHAR_ADDR_W'(used_ent) * sdh_pkg::CHAR_ADDR_W'(sdh_pkg::MAX_LEN);
            idx_reg  <= '0;
        end
        else if (cmd.cmp_step || cmd.copy_step)
        begin
            idx_reg <= idx_reg + sdh_pkg::LEN_W'(1);
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_code;
            case (cmd.res_code)
                sdh_pkg::ST_DROP: res_index_reg <= '0;
                sdh_pkg::ST_NEW:  res_index_reg <= sdh_pkg::IDX_W'(used_ent);
                default:          res_index_reg <= sdh_pkg::IDX_W'(cur_ent);
            endcase
        end
        if (cmd.load_result)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
        end
    end

    // Write port selection for the bucket heads and next links
    always_comb
    begin
        head_we  = 1'b0;
        head_wa  = hash_reg[sdh_pkg::BKT_W-1:0];
        head_wd  = used_reg + sdh_pkg::LINK_W'(1);
        enext_we = 1'b0;
        enext_wa = used_ent;
        enext_wd = '0;
        if (cmd.clr_step)
        begin
            head_we = 1'b1;
            head_wa = clr_reg[sdh_pkg::BKT_W-1:0];
            head_wd = '0;
        end
        else if (cmd.link_write && tail_reg == '0)
        begin
            head_we = 1'b1;
        end
        if (cmd.new_start)
        begin
            enext_we = 1'b1;
        end
        else if (cmd.link_write && tail_reg != '0)
        begin
            enext_we = 1'b1;
            enext_wa = tail_ent;
            enext_wd = used_reg + sdh_pkg::LINK_W'(1);
        end
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        if (cmd.hash_rd)
        begin
            head_rd <= head_mem[hash_reg[sdh_pkg::BKT_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && char_nz && len_reg < sdh_pkg::LEN_W'(sdh_pkg::MAX_LEN))
        begin
            lbuf_mem[len_reg] <= char_code;
        end
        if (cmd.cmp_step || cmd.copy_step)
        begin
            lbuf_rd <= lbuf_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.copy_step && idx_reg != '0)
        begin
            char_mem[base_reg + sdh_pkg::CHAR_ADDR_W'(idx_m1)] <= lbuf_rd;
        end
        if (cmd.cmp_step)
        begin
            char_rd <= char_mem[base_reg + sdh_pkg::CHAR_ADDR_W'(idx_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.new_start)
        begin
            elen_mem[used_ent] <= len_reg;
        end
        if (cmd.ent_rd)
        begin
            elen_rd <= elen_mem[cur_ent];
        end
    end

    always_ff @(posedge clk)
    begin
        if (enext_we)
        begin
            enext_mem[enext_wa] <= enext_wd;
        end
        if (cmd.ent_rd)
        begin
            enext_rd <= enext_mem[cur_ent];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.new_start)
        begin
            erep_mem[used_ent] <= 1'b0;
        end
        else if (cmd.mark_reported)
        begin
            erep_mem[cur_ent] <= 1'b1;
        end
        if (cmd.ent_rd)
        begin
            erep_rd <= erep_mem[cur_ent];
        end
    end

    assign st.clr_done   = (clr_reg == sdh_pkg::CLR_W'(sdh_pkg::BUCKETS));
    assign st.overlong   = overlong_reg;
    assign st.link_zero  = (link_reg == '0);
    assign st.len_match  = (elen_rd == len_reg);
    assign st.len_zero   = (len_reg == '0);
    assign st.char_match = (char_rd == lbuf_rd);
    assign st.idx_at_len = (idx_reg == len_reg);
    assign st.pool_full  = (used_reg == sdh_pkg::LINK_W'(sdh_pkg::ENTRIES));
    assign st.reported   = erep_rd;

    assign result_status = out_status_reg;
    assign result_index  = out_index_reg;
endmodule

/* design/sdh_ctrl.sv */
// Controller state machine: clear sweep, lookup, compare, store, result.
`timescale 1ns / 1ps
module sdh_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           char_valid,
    input  logic           char_last,
    output logic           char_ready,
    output logic           result_valid,
    input  logic           result_ready,
    input  sdh_pkg::stat_t st,
    output sdh_pkg::cmd_t  cmd
);
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_START  = 4'd2;
    localparam logic [3:0] S_HEAD   = 4'd3;
    localparam logic [3:0] S_CHK    = 4'd4;
    localparam logic [3:0] S_LEN    = 4'd5;
    localparam logic [3:0] S_CMP    = 4'd6;
    localparam logic [3:0] S_MATCH  = 4'd7;
    localparam logic [3:0] S_COPY   = 4'd8;
    localparam logic [3:0] S_LINKUP = 4'd9;
    localparam logic [3:0] S_RESULT = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       slot_free;

    assign char_ready = (state_reg == S_IDLE);
    assign slot_free  = !ovalid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                if (st.clr_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.clr_step = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (char_valid)
                begin
                    cmd.accept = 1'b1;
                    if (char_last)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                if (st.overlong)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = sdh_pkg::ST_DROP;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.hash_rd = 1'b1;
                    state_next  = S_HEAD;
                end
            end
            S_HEAD:
            begin
                cmd.head_load = 1'b1;
                state_next    = S_CHK;
            end
            S_CHK:
            begin
                if (!st.link_zero)
                begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_LEN;
                end
                else if (st.pool_full)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = sdh_pkg::ST_DROP;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.new_start = 1'b1;
                    state_next    = S_COPY;
                end
            end
            S_LEN:
            begin
                if (!st.len_match)
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_CHK;
                end
                else if (st.len_zero)
                begin
                    state_next = S_MATCH;
                end
                else
                begin
                    cmd.cmp_step = 1'b1;
                    state_next   = S_CMP;
                end
            end
            S_CMP:
            begin
                if (!st.char_match)
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_CHK;
                end
                else if (st.idx_at_len)
                begin
                    state_next = S_MATCH;
                end
                else
                begin
                    cmd.cmp_step = 1'b1;
                end
            end
            S_MATCH:
            begin
                cmd.res_set       = 1'b1;
                cmd.res_code      = st.reported ? sdh_pkg::ST_LATER : sdh_pkg::ST_FIRST;
                cmd.mark_reported = 1'b1;
                state_next        = S_RESULT;
            end
            S_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (st.idx_at_len)
                begin
                    state_next = S_LINKUP;
                end
            end
            S_LINKUP:
            begin
                cmd.link_write = 1'b1;
                cmd.res_set    = 1'b1;
                cmd.res_code   = sdh_pkg::ST_NEW;
                state_next     = S_RESULT;
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    cmd.load_result = 1'b1;
                    cmd.clear_line  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.load_result)
        begin
            ovalid_next = 1'b1;
        end
        else if (result_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign result_valid = ovalid_reg;
endmodule

/* design/string_dedup_hash_table.sv */
// Top level of the string deduplication hash set.
`timescale 1ns / 1ps
// Lines enter one character per request on chars, the final character
// marked by last_char; a zero byte is skipped, and a zero byte with
// last_char ends the line as it stands. Characters that do not end a line
// are taken one per cycle while chars is ready; ready is low from a line
// end until its result is loaded. A line end hashes into one of 4096
// buckets: the bucket head is read (S_START, S_HEAD), then each chain
// entry gets a length check (S_CHK, S_LEN) and, where the lengths match,
// a byte compare (S_CMP). A match is reported from S_MATCH; a new line
// starts the store in S_CHK, copies its bytes in S_COPY and is linked in
// S_LINKUP. An over-long line skips the lookup. S_RESULT moves the result
// into the output register once that is free. One result request per
// line: status 0 new and stored, 1 first repeat, 2 later repeat, 3 dropped
// (pool of 4096 entries full, or line over 40 characters) with entry_index
// 0. After reset the bucket heads are swept to empty; chars is held not
// ready until the sweep is done. A finished result waits in an output
// register and the next line's characters are taken meanwhile.
module string_dedup_hash_table (
    input logic          clk,
    input logic          rst_n,
    sdh_char_if.sink     chars,
    sdh_result_if.source results
);
    sdh_pkg::cmd_t  cmd;
    sdh_pkg::stat_t st;

    // Sequence lookup, compare and store
    sdh_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (chars.valid),
        .char_last    (chars.last_char),
        .char_ready   (chars.ready),
        .result_valid (results.valid),
        .result_ready (results.ready),
        .st           (st),
        .cmd          (cmd)
    );

    // Hold hash, line buffer, table memories and the result register
    sdh_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .char_code     (chars.char_code),
        .st            (st),
        .result_status (results.status),
        .result_index  (results.entry_index)
    );

    // A dropped line reports entry 0
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.status == sdh_pkg::ST_DROP |-> results.entry_index == '0)
        else $error("dropped line reports a nonzero entry");

    // No character is taken before the bucket sweep ends
    assert property (@(posedge clk) disable iff (!rst_n)
        !st.clr_done |-> !chars.ready)
        else $error("character accepted during bucket sweep");

    // A new result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> !(results.valid && !results.ready))
        else $error("pending result overwritten");
endmodule

/* tb/tb_if.sv */
// Interface declarations are provided by the design; this file holds the test-side package.
`timescale 1ns / 1ps
package tb_line_pkg;
    typedef struct {
        logic [1:0]  status;
        logic [11:0] entry_index;
    } dedup_result_t;
endpackage

/* tb/tb_top.sv */
// Self-checking testbench for the string deduplication hash set.
`timescale 1ns / 1ps
module tb_top;
    import sdh_pkg::*;
    import tb_line_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #5 clk = ~clk;

    sdh_char_if   chars ();
    sdh_result_if results ();

    string_dedup_hash_table uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars.sink),
        .results (results.source)
    );

    // Predictor state: a line-level model of the set.
    logic [31:0]       line_hash;
    logic [7:0]        line_bytes [MAX_LEN];
    int unsigned       line_len;
    bit                line_too_long;
    int unsigned       head_link [BUCKETS];
    logic [7:0]        pool_chars [ENTRIES][MAX_LEN];
    int unsigned       pool_len [ENTRIES];
    int unsigned       pool_next [ENTRIES];
    bit                pool_reported [ENTRIES];
    int unsigned       pool_used;

    dedup_result_t     expected_results [$];
    int                mismatches;
    int                results_seen;
    int                lines_sent;
    bit                failed;
    int                send_idle_pct;
    int                recv_stall_pct;
    longint            cycle_count;

    // Hold a stored pool of earlier random lines to replay as repeats.
    typedef struct {
        logic [7:0] bytes [$];
    } line_t;
    line_t             sent_lines [$];

    // Compute the outcome of one finished line and update the set.
    function automatic dedup_result_t finish_line_predict();
        dedup_result_t r;
        int unsigned b, link, tail, e;
        bit same;
        r.status = ST_DROP;
        r.entry_index = '0;
        b = line_hash % BUCKETS;
        link = head_link[b];
        tail = 0;
        if (!line_too_long)
        begin
            while (link != 0)
            begin
                e = link - 1;
                same = (pool_len[e] == line_len);
                for (int i = 0; same && i < line_len; i++)
                    if (pool_chars[e][i] != line_bytes[i]) same = 0;
                if (same)
                begin
                    r.status = pool_reported[e] ? ST_LATER : ST_FIRST;
                    pool_reported[e] = 1;
                    r.entry_index = e[11:0];
                    return r;
                end
                tail = link;
                link = pool_next[e];
            end
            if (pool_used < ENTRIES)
            begin
                e = pool_used;
                pool_used++;
                for (int i = 0; i < line_len; i++) pool_chars[e][i] = line_bytes[i];
                pool_len[e] = line_len;
                pool_next[e] = 0;
                pool_reported[e] = 0;
                if (tail == 0) head_link[b] = e + 1;
                else pool_next[tail - 1] = e + 1;
                r.status = ST_NEW;
                r.entry_index = e[11:0];
            end
        end
        return r;
    endfunction

    // Advance the predictor by one accepted character request.
    function automatic void predict_char(logic [7:0] c, logic last);
        logic [31:0] ext;
        if (c != 0)
        begin
            ext = {{24{c[7]}}, c};
            line_hash = {line_hash[26:0], line_hash[31:27]} + ext;
            if (line_len < MAX_LEN)
            begin
                line_bytes[line_len] = c;
                line_len++;
            end
            else
                line_too_long = 1;
        end
        if (last)
        begin
            expected_results.push_back(finish_line_predict());
            line_hash = '0;
            line_len = 0;
            line_too_long = 0;
        end
    endfunction

    // Send one character request, idling first at the current rate.
    // Valid stays high after acceptance; the next request or an idle
    // cycle replaces it.
    task automatic send_char(logic [7:0] c, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            chars.valid <= 1'b0;
            @(posedge clk);
        end
        chars.valid     <= 1'b1;
        chars.char_code <= c;
        chars.last_char <= last;
        do @(posedge clk); while (!chars.ready);
        predict_char(c, last);
    endtask

    // Send a whole line; the last byte carries the end mark.
    task automatic send_line(line_t l);
        if (l.bytes.size() == 0)
            send_char(8'd0, 1'b1);
        else
            for (int i = 0; i < l.bytes.size(); i++)
                send_char(l.bytes[i], i == l.bytes.size() - 1);
        lines_sent++;
    endtask

    function automatic line_t random_line(int max_len);
        line_t l;
        int n;
        n = $urandom_range(max_len);
        for (int i = 0; i < n; i++)
            l.bytes.push_back(8'($urandom_range(1, 255)));
        return l;
    endfunction

    // Lines that exercise the field extremes and each special case.
    task automatic test_directed();
        line_t l;
        send_line(l);                        // empty line, stored
        send_line(l);                        // first repeat
        send_line(l);                        // later repeat
        l.bytes = '{8'h01};
        send_line(l);
        l.bytes = '{8'hFF, 8'h80, 8'h7F};    // sign-extended bytes
        send_line(l);
        send_line(l);
        // Zero byte mid-line is skipped: same line as above.
        send_char(8'hFF, 0); send_char(8'h00, 0); send_char(8'h80, 0);
        send_char(8'h7F, 1);
        lines_sent++;
        l.bytes = '{8'h41, 8'h42, 8'h00};    // zero byte with end mark ends line
        send_line(l);
        l.bytes = {};
        for (int i = 0; i < MAX_LEN; i++) l.bytes.push_back(8'(i + 1));
        send_line(l);                        // exactly max length
        send_line(l);
        l.bytes.push_back(8'hAA);            // one over: dropped
        send_line(l);
        // Same bytes, different length: distinct lines.
        l.bytes = '{8'h61, 8'h61};
        send_line(l);
        l.bytes = '{8'h61};
        send_line(l);
    endtask

    // Random traffic, nearly half repeats of earlier lines to walk chains.
    task automatic test_random(int n_lines);
        line_t l;
        int pick;
        for (int k = 0; k < n_lines; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 45 && sent_lines.size() > 0)
                l = sent_lines[$urandom_range(sent_lines.size() - 1)];
            else if (pick < 50)
                l = random_line(MAX_LEN + 6);
            else
            begin
                l = random_line(8);
                if (sent_lines.size() < 200) sent_lines.push_back(l);
            end
            send_line(l);
        end
    endtask

    // Collide many short lines into the same buckets via a fixed char set.
    task automatic test_chain_collisions(int n_lines);
        line_t l;
        for (int k = 0; k < n_lines; k++)
        begin
            l.bytes = {};
            repeat ($urandom_range(1, 3))
                l.bytes.push_back($urandom_range(1) ? 8'h20 : 8'h40);
            send_line(l);
        end
    endtask

    task automatic wait_drain();
        chars.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Result checker with random stall on ready.
    always @(posedge clk)
    begin
        if (!rst_n)
            results.ready <= 1'b0;
        else
        begin
            if (results.valid && results.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result status=%0d index=%0d",
                                 results.status, results.entry_index);
                end
                else
                begin
                    automatic dedup_result_t x = expected_results.pop_front();
                    if (x.status !== results.status || x.entry_index !== results.entry_index)
                    begin
                        failed = 1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected status=%0d index=%0d, got %0d %0d",
                                     x.status, x.entry_index, results.status,
                                     results.entry_index);
                    end
                end
            end
            results.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Cycle limit: generous against the slow end with stalls.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 1000000)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        chars.valid     <= 1'b0;
        chars.char_code <= '0;
        chars.last_char <= 1'b0;
        line_hash = '0; line_len = 0; line_too_long = 0; pool_used = 0;
        foreach (head_link[i]) head_link[i] = 0;
        mismatches = 0; results_seen = 0; lines_sent = 0; failed = 0;
        cycle_count = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 7;  recv_stall_pct = 81;
        test_directed();
        test_random(12);
        test_chain_collisions(15);
        send_idle_pct = 81; recv_stall_pct = 7;
        test_random(12);
        send_idle_pct = 0;  recv_stall_pct = 0;
        test_random(16);
        test_chain_collisions(15);
        wait_drain();

        if (expected_results.size() != 0) failed = 1;
        $display("run covered %0d lines, %0d results, %0d pool entries in use",
                 lines_sent, results_seen, pool_used);
        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

/* string_dedup_hash_table.f */
design/sdh_pkg.sv
design/sdh_if.sv
design/sdh_datapath.sv
design/sdh_ctrl.sv
design/string_dedup_hash_table.sv
tb/tb_if.sv
tb/tb_top.sv
